FILE: sv/assert_macros.svh
// Assertion macros for the RTL of the bounded min-priority set.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: sv/bmps_pkg.sv
// Package for the bounded min-priority set: widths, defaults, status codes
// and the cell control struct. No dependencies.
package bmps_pkg;

    localparam int DEPTH_DEFAULT     = 32;
    localparam int KEY_WIDTH_DEFAULT = 32;
    localparam int KEY_IO_W          = 32;
    localparam int OCC_W             = 6;
    localparam int CAP_W             = 6;
    localparam logic [CAP_W-1:0] CAP_RESET = 6'd20;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_REMOVED   = 3'd2,
        ST_FULL      = 3'd3,
        ST_EMPTY     = 3'd4
    } t_status;

    typedef struct packed {
        logic cmp;
        logic ins;
        logic ext;
    } t_cell_ctl;

endpackage

FILE: sv/bmps_req_if.sv
// Request channel of the bounded min-priority set: valid/ready plus mode and key.
// Depends on bmps_pkg.
interface bmps_req_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  mode;
    logic signed [bmps_pkg::KEY_IO_W-1:0]  key_in;

    modport source (output valid, output mode, output key_in, input ready);
    modport sink   (input valid, input mode, input key_in, output ready);
endinterface

FILE: sv/bmps_rsp_if.sv
// Response channel of the bounded min-priority set: valid/ready plus key,
// status and occupancy. Depends on bmps_pkg.
interface bmps_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [bmps_pkg::KEY_IO_W-1:0]  key_out;
    bmps_pkg::t_status                     status;
    logic [bmps_pkg::OCC_W-1:0]            occupancy;

    modport source (output valid, output key_out, output status, output occupancy,
                    input ready);
    modport sink   (input valid, input key_out, input status, input occupancy,
                    output ready);
endinterface

FILE: sv/bounded_min_priority_set.sv
// Top level of the bounded min-priority set: a row of sorted key cells,
// the request sequencer and the response register.
// Depends on bmps_pkg, bmps_req_if, bmps_rsp_if, bmps_cell, assert_macros.svh.
//
// Usage:
//   i_req carries one request per transfer: mode 0 inserts key_in, mode 1
//   extracts the smallest held key. o_rsp returns exactly one response per
//   request with key_out, status and the occupancy after the request.
//   i_cfg_we/i_cfg_wdata write the capacity limit; write only while idle.
// Sequencing:
//   A request passes through the transfer cycle, the compare state in which
//   every cell compares its key with the request key, and the apply state in
//   which the row shifts and the response register loads. No new request is
//   taken before the last one is applied; the cell row's compare and shift set this.
// Reset:
//   i_rst_n low clears the key count, the sequencer and the response valid
//   and sets the capacity limit to 20. Cell contents are not cleared.
// Stall:
//   The response register holds while o_rsp.ready is low; a request taken in
//   that time completes its compare and then waits in the shift cycle.
module bounded_min_priority_set #(
    parameter int DEPTH     = bmps_pkg::DEPTH_DEFAULT,
    parameter int KEY_WIDTH = bmps_pkg::KEY_WIDTH_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    bmps_req_if.sink                     i_req,
    bmps_rsp_if.source                   o_rsp,
    input  logic                         i_cfg_we,
    input  logic [bmps_pkg::CAP_W-1:0]   i_cfg_wdata
);
    import bmps_pkg::*;
    `include "assert_macros.svh"

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_APPLY
    } t_state;

    t_state                      r_state;
    logic [CNT_W-1:0]            r_count;
    logic [CNT_W-1:0]            n_count;
    logic [CAP_W-1:0]            r_capacity;
    logic                        r_mode;
    logic signed [KEY_WIDTH-1:0] r_key;
    logic signed [KEY_WIDTH-1:0] key_store;
    logic                        r_out_valid;
    logic signed [KEY_IO_W-1:0]  r_key_out;
    logic signed [KEY_IO_W-1:0]  n_key_out;
    logic signed [KEY_IO_W-1:0]  head_out;
    t_status                     r_status;
    t_status                     n_status;
    logic [OCC_W-1:0]            r_occ;

    logic signed [KEY_WIDTH-1:0] w_key [DEPTH];
    logic [DEPTH-1:0]            w_lt;
    logic [DEPTH-1:0]            w_eq;

    t_cell_ctl                   cell_ctl;
    logic                        apply_go;
    logic                        full;
    logic                        empty;
    logic                        dup;

    generate
        if (KEY_WIDTH <= KEY_IO_W) begin : g_narrow
            assign key_store = i_req.key_in[KEY_WIDTH-1:0];
            if (KEY_WIDTH == KEY_IO_W) begin : g_same
                assign head_out = w_key[0];
            end else begin : g_ext
                assign head_out = {{(KEY_IO_W-KEY_WIDTH){w_key[0][KEY_WIDTH-1]}}, w_key[0]};
            end
        end else begin : g_wide
            assign key_store = {{(KEY_WIDTH-KEY_IO_W){i_req.key_in[KEY_IO_W-1]}},
                                i_req.key_in};
            assign head_out  = w_key[0][KEY_IO_W-1:0];
        end
    endgenerate

    assign full  = (CMP_W'(r_count) >= CMP_W'(r_capacity)) || (r_count == CNT_W'(DEPTH));
    assign empty = (r_count == '0);
    assign dup   = |w_eq;

    assign apply_go     = (r_state == S_APPLY) && (!r_out_valid || o_rsp.ready);
    assign cell_ctl.cmp = (r_state == S_CMP);
    assign cell_ctl.ins = apply_go && !r_mode && !full && !dup;
    assign cell_ctl.ext = apply_go && r_mode && !empty;

    always_comb begin
        n_count   = r_count;
        n_key_out = '0;
        if (!r_mode) begin
            if (full) begin
                n_status = ST_FULL;
            end else if (dup) begin
                n_status = ST_DUPLICATE;
            end else begin
                n_status = ST_INSERTED;
                n_count  = r_count + 1'b1;
            end
        end else begin
            if (empty) begin
                n_status = ST_EMPTY;
            end else begin
                n_status  = ST_REMOVED;
                n_count   = r_count - 1'b1;
                n_key_out = head_out;
            end
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic signed [KEY_WIDTH-1:0] prev_key;
            logic                        prev_lt;
            logic signed [KEY_WIDTH-1:0] next_key;
            if (gi == 0) begin : g_first
                assign prev_key = w_key[0];
                assign prev_lt  = 1'b1;
            end else begin : g_mid
                assign prev_key = w_key[gi-1];
                assign prev_lt  = w_lt[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_last
                assign next_key = w_key[gi];
            end else begin : g_inner
                assign next_key = w_key[gi+1];
            end
            bmps_cell #(
                .KEY_WIDTH (KEY_WIDTH),
                .CNT_W     (CNT_W),
                .INDEX     (gi)
            ) u_cell (
                .i_clk      (i_clk),
                .i_ctl      (cell_ctl),
                .i_key      (r_key),
                .i_count    (r_count),
                .i_prev_key (prev_key),
                .i_prev_lt  (prev_lt),
                .i_next_key (next_key),
                .o_key      (w_key[gi]),
                .o_lt       (w_lt[gi]),
                .o_eq       (w_eq[gi])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_capacity  <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
            if (o_rsp.ready && !apply_go) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_APPLY;
                end
                S_APPLY: begin
                    if (apply_go) begin
                        r_state     <= S_IDLE;
                        r_count     <= n_count;
                        r_out_valid <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
        if (r_state == S_IDLE) begin
            r_mode <= i_req.mode;
            r_key  <= key_store;
        end
        if (apply_go) begin
            r_key_out <= n_key_out;
            r_status  <= n_status;
            r_occ     <= OCC_W'(n_count);
        end
    end

    assign i_req.ready     = (r_state == S_IDLE);
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.key_out   = r_key_out;
    assign o_rsp.status    = r_status;
    assign o_rsp.occupancy = r_occ;

    `ASSERT_IMPLIES(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH))
    `ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_req.valid && i_req.ready, !i_req.ready)
    `ASSERT_NEXT(a_insert_grows, i_clk, i_rst_n, apply_go && (n_status == ST_INSERTED), r_count == $past(r_count) + 1'b1)
    `ASSERT_NEXT(a_remove_shrinks, i_clk, i_rst_n, apply_go && (n_status == ST_REMOVED), r_count == $past(r_count) - 1'b1)

endmodule

FILE: sv/bmps_cell.sv
// One cell of the sorted key row: holds a key, compares it with the request
// key and shifts toward either neighbor. Depends on bmps_pkg.
module bmps_cell #(
    parameter int KEY_WIDTH = bmps_pkg::KEY_WIDTH_DEFAULT,
    parameter int CNT_W     = 6,
    parameter int INDEX     = 0
) (
    input  logic                        i_clk,
    input  bmps_pkg::t_cell_ctl         i_ctl,
    input  logic signed [KEY_WIDTH-1:0] i_key,
    input  logic [CNT_W-1:0]            i_count,
    input  logic signed [KEY_WIDTH-1:0] i_prev_key,
    input  logic                        i_prev_lt,
    input  logic signed [KEY_WIDTH-1:0] i_next_key,
    output logic signed [KEY_WIDTH-1:0] o_key,
    output logic                        o_lt,
    output logic                        o_eq
);
    import bmps_pkg::*;

    logic signed [KEY_WIDTH-1:0] r_key;
    logic signed [KEY_WIDTH-1:0] n_key;
    logic                        r_lt;
    logic                        r_eq;
    logic                        occ;

    assign occ = CNT_W'(INDEX) < i_count;

    always_comb begin
        n_key = r_key;
        if (i_ctl.ins && !r_lt) begin
            n_key = i_prev_lt ? i_key : i_prev_key;
        end else if (i_ctl.ext) begin
            n_key = i_next_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_lt <= occ && (r_key < i_key);
            r_eq <= occ && (r_key == i_key);
        end
        r_key <= n_key;
    end

    assign o_key = r_key;
    assign o_lt  = r_lt;
    assign o_eq  = r_eq;

endmodule
